FILE: sv/lrt_pkg.sv
`default_nettype none
package lrt_pkg;

  localparam int NUM_PIXELS      = 64;
  localparam int PIXEL_BITS      = 5;
  localparam int FRAC_BITS       = 16;
  localparam int SIGMOID_ENTRIES = 256;

  localparam int ROW_BITS    = 40;
  localparam int NUM_ROWS    = 8;
  localparam int PIX_PER_ROW = (NUM_PIXELS + NUM_ROWS - 1) / NUM_ROWS;
  localparam int ROW_AW      = $clog2(NUM_ROWS);
  localparam int LANE_W      = $clog2(PIX_PER_ROW);
  localparam int CNT_W       = $clog2(NUM_ROWS + 1);

  localparam int WEIGHT_W = 32;
  localparam int PROB_W   = FRAC_BITS + 1;
  localparam int LR_W     = 16;
  localparam int IDX_W    = 7;
  localparam int SIG_AW   = $clog2(SIGMOID_ENTRIES);

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] CFG_LEARN_RATE   = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_UPDATE_INDEX = 1'd1;
  localparam logic [LR_W-1:0]   LEARN_RATE_RST   = 16'd44;
  localparam logic [IDX_W-1:0]  UPDATE_INDEX_RST = 7'd1;

  typedef logic [PIX_PER_ROW-1:0][WEIGHT_W-1:0] wrow_t;

  typedef struct packed {
    logic                req_type;
    logic [ROW_BITS-1:0] row0;
    logic [ROW_BITS-1:0] row1;
    logic [ROW_BITS-1:0] row2;
    logic [ROW_BITS-1:0] row3;
    logic [ROW_BITS-1:0] row4;
    logic [ROW_BITS-1:0] row5;
    logic [ROW_BITS-1:0] row6;
    logic [ROW_BITS-1:0] row7;
    logic                label;
  } lrt_in_t;

  typedef struct packed {
    logic [PROB_W-1:0]          probability;
    logic                       predicted_class;
    logic signed [WEIGHT_W-1:0] updated_weight;
  } lrt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SIG_IDX,
    ST_SIG_LUT,
    ST_MUL_ERR,
    ST_MUL_PIX,
    ST_UPDATE,
    ST_FINISH
  } lrt_state_t;

  // Sigmoid table, built at elaboration in Q30 integer arithmetic
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0] EXP_NEG1_Q30 = 64'd395007542;
  localparam int          TAYLOR_TERMS = 20;

  typedef logic [PROB_W-1:0] sig_tab_t [SIGMOID_ENTRIES];

  // restoring long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
    logic [63:0] m;
    logic [63:0] f;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] p;
    m    = t >> 30;
    f    = t & (Q30_ONE - 64'd1);
    sum  = Q30_ONE;
    term = Q30_ONE;
    p    = Q30_ONE;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = udiv64((term * f) >> 30, 64'(n));
      sum  = sum + term;
    end
    for (int i = 0; i < 16; i++) begin
      if (64'(i) < m) p = (p * EXP_NEG1_Q30 + (Q30_ONE >> 1)) >> 30;
    end
    return udiv64((p << 30) + (sum >> 1), sum);
  endfunction

  function automatic sig_tab_t build_sig();
    sig_tab_t    tab;
    logic [63:0] e;
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] v;
    logic        nonneg;
    e = 64'(SIGMOID_ENTRIES);
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      nonneg = (64'(2 * k) >= e);
      a      = nonneg ? (64'(2 * k) - e) : (e - 64'(2 * k));
      t      = udiv64(a << 33, e);
      q      = exp_neg_q30(t);
      den    = Q30_ONE + q;
      num    = nonneg ? (64'd1 << 46) : (q << 16);
      v      = udiv64(num + (den >> 1), den);
      tab[k] = v[PROB_W-1:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig();

endpackage
`default_nettype wire

FILE: sv/logistic_regression_trainer.sv
// An accepted request runs a row-by-row weight scan through the single read port of the
// weight memory, then index, table, two multiplies and write-back; a new request is taken
// only once the previous result has been loaded into the output register.
// Reset (synchronous, rst_n low): weights read as zero through per-row valid bits, so no
// clearing pass is needed; learn_rate returns to 44, update_index to 1, output empties.
`default_nettype none
module logistic_regression_trainer (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire lrt_pkg::lrt_in_t          in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output lrt_pkg::lrt_out_t              out_data,
  input  wire                            cfg_we,
  input  wire [lrt_pkg::CFG_AW-1:0]      cfg_addr,
  input  wire [lrt_pkg::CFG_DW-1:0]      cfg_wdata
);
  import lrt_pkg::*;

  localparam int PROD_W = WEIGHT_W + PIXEL_BITS + 1;
  localparam int ACC_W  = PROD_W + $clog2(NUM_PIXELS + 1);
  localparam int M1_W   = LR_W + PROB_W;
  localparam int MAG_W  = M1_W + PIXEL_BITS;
  localparam int SH     = 32 - FRAC_BITS;
  localparam int D_W    = MAG_W + 1 - SH;
  localparam int SUM_W  = WEIGHT_W + 2;

  localparam logic signed [ACC_W-1:0] SIG_LIM = ACC_W'(64'd1 << (FRAC_BITS + 3));
  localparam logic [SIG_AW-1:0]       IDX_MAX = SIG_AW'(SIGMOID_ENTRIES - 1);
  localparam logic [PROB_W-1:0]       P_ONE   = PROB_W'(64'd1 << FRAC_BITS);
  localparam logic [PROB_W-1:0]       P_HALF  = PROB_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [MAG_W:0]          RND     = (MAG_W + 1)'(64'd1 << (SH - 1));
  localparam logic signed [SUM_W-1:0] W_MAX   =
    {{(SUM_W - WEIGHT_W + 1){1'b0}}, {(WEIGHT_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] W_MIN   = ~W_MAX;

  // ---------------- configuration ----------------
  logic [LR_W-1:0]  learn_rate_r;
  logic [IDX_W-1:0] update_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r   <= LEARN_RATE_RST;
      update_index_r <= UPDATE_INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LEARN_RATE:   learn_rate_r   <= cfg_wdata[LR_W-1:0];
        CFG_UPDATE_INDEX: update_index_r <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // selected weight position, pixel p = index - 1 sits at row p / lanes, lane p % lanes
  logic [IDX_W-1:0]  sel_p;
  logic [IDX_W-1:0]  sel_row;
  logic [LANE_W-1:0] sel_lane;
  logic              sel_ok;

  assign sel_p    = update_index_r - IDX_W'(1);
  assign sel_row  = IDX_W'(sel_p / PIX_PER_ROW);
  assign sel_lane = LANE_W'(sel_p % PIX_PER_ROW);
  assign sel_ok   = (update_index_r >= IDX_W'(1)) && (update_index_r <= IDX_W'(NUM_PIXELS));

  // ---------------- control ----------------
  lrt_state_t state_r, state_nxt;
  logic       in_acc;
  logic       rd_en;
  logic       mem_we;
  logic       out_load;
  logic       scan_done;
  logic       out_valid_r;
  logic       req_r, label_r;

  logic [CNT_W-1:0]  rd_cnt_r;
  logic [ROW_AW-1:0] raddr;
  logic              p1_vld_r, p2_vld_r;
  logic [ROW_AW-1:0] p1_row_r, p2_row_r;
  logic              p1_ok_r;

  assign raddr     = rd_cnt_r[ROW_AW-1:0];
  assign scan_done = p2_vld_r && (p2_row_r == ROW_AW'(NUM_ROWS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:    if (scan_done) state_nxt = ST_SIG_IDX;
      ST_SIG_IDX: state_nxt = ST_SIG_LUT;
      ST_SIG_LUT: state_nxt = ST_MUL_ERR;
      ST_MUL_ERR: state_nxt = ST_MUL_PIX;
      ST_MUL_PIX: state_nxt = ST_UPDATE;
      ST_UPDATE:  state_nxt = ST_FINISH;
      ST_FINISH:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   rd_en    = (rd_cnt_r < CNT_W'(NUM_ROWS));
      ST_UPDATE: mem_we   = req_r && sel_ok;
      ST_FINISH: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= rd_en;
      p2_vld_r <= p1_vld_r;
      if (in_acc)     rd_cnt_r <= '0;
      else if (rd_en) rd_cnt_r <= rd_cnt_r + CNT_W'(1);
    end
  end

  // ---------------- request capture ----------------
  logic [ROW_BITS-1:0]   rows [NUM_ROWS];
  logic [PIXEL_BITS-1:0] pix_r [NUM_ROWS][PIX_PER_ROW];

  always_comb begin
    rows[0] = in_data.row0;
    rows[1] = in_data.row1;
    rows[2] = in_data.row2;
    rows[3] = in_data.row3;
    rows[4] = in_data.row4;
    rows[5] = in_data.row5;
    rows[6] = in_data.row6;
    rows[7] = in_data.row7;
  end

  // pixel 1 of a row sits in its low bits; lanes past the row width read as zero
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_data.req_type;
      label_r <= in_data.label;
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int l = 0; l < PIX_PER_ROW; l++) begin
          if ((l + 1) * PIXEL_BITS <= ROW_BITS) pix_r[r][l] <= rows[r][l * PIXEL_BITS +: PIXEL_BITS];
          else                                  pix_r[r][l] <= '0;
        end
      end
    end
  end

  // ---------------- weight memory ----------------
  // One row holds the weights of one pixel row. Reads happen only while scanning and the
  // single write only in the update state, so the two never meet on the same row.
  // There is no bias entry in the memory, so z holds no bias term.
  wrow_t                 weight_mem [NUM_ROWS];
  logic [NUM_ROWS-1:0]   row_vld_r;
  wrow_t                 rdata_r;
  wrow_t                 wr_data;
  logic [ROW_AW-1:0]     wr_row;

  assign wr_row = sel_row[ROW_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) weight_mem[wr_row] <= wr_data;
    if (rd_en)  rdata_r <= weight_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      row_vld_r <= '0;
    else if (mem_we) row_vld_r[wr_row] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p1_row_r <= raddr;
      p1_ok_r  <= row_vld_r[raddr];
    end
    if (p1_vld_r) p2_row_r <= p1_row_r;
  end

  // ---------------- dot product ----------------
  wrow_t                    rd_row;
  logic signed [PROD_W-1:0] prod_r [PIX_PER_ROW];
  logic signed [ACC_W-1:0]  lane_sum;
  logic signed [ACC_W-1:0]  acc_r;
  wrow_t                    sel_data_r;

  // a row never written reads as zero
  assign rd_row = p1_ok_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (p1_vld_r) begin
      for (int l = 0; l < PIX_PER_ROW; l++) begin
        prod_r[l] <= $signed(rd_row[l]) * $signed({1'b0, pix_r[p1_row_r][l]});
      end
      if (IDX_W'(p1_row_r) == sel_row) sel_data_r <= rd_row;
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int l = 0; l < PIX_PER_ROW; l++) lane_sum = lane_sum + ACC_W'(prod_r[l]);
  end

  always_ff @(posedge clk) begin
    if (in_acc)        acc_r <= '0;
    else if (p2_vld_r) acc_r <= acc_r + lane_sum;
  end

  // ---------------- sigmoid ----------------
  logic signed [ACC_W-1:0] z_off;
  logic [SIG_AW-1:0]       idx_r;
  logic [PROB_W-1:0]       prob_r;

  assign z_off = acc_r + SIG_LIM;

  always_ff @(posedge clk) begin
    if (state_r == ST_SIG_IDX) begin
      if (acc_r < -SIG_LIM)      idx_r <= '0;
      else if (acc_r >= SIG_LIM) idx_r <= IDX_MAX;
      else                       idx_r <= z_off[FRAC_BITS+3 -: SIG_AW];
    end
    if (state_r == ST_SIG_LUT) prob_r <= SIG_TABLE[idx_r];
  end

  // ---------------- gradient step ----------------
  logic [PROB_W-1:0]          err;
  logic [M1_W-1:0]            m1_r;
  logic [MAG_W-1:0]           mag_r;
  logic [MAG_W:0]             mag_rnd;
  logic [D_W-1:0]             step;
  logic signed [SUM_W-1:0]    w_ext;
  logic signed [SUM_W-1:0]    w_sum;
  logic signed [WEIGHT_W-1:0] w_cur;
  logic signed [WEIGHT_W-1:0] w_new;
  logic signed [WEIGHT_W-1:0] wout;

  assign err = label_r ? (P_ONE - prob_r) : prob_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_ERR) m1_r  <= learn_rate_r * err;
    if (state_r == ST_MUL_PIX) mag_r <= m1_r * pix_r[sel_row[ROW_AW-1:0]][sel_lane];
  end

  // round the magnitude half away from zero, then add or subtract with saturation
  assign mag_rnd = {1'b0, mag_r} + RND;
  assign step    = mag_rnd[MAG_W:SH];
  assign w_cur   = $signed(sel_data_r[sel_lane]);
  assign w_ext   = SUM_W'(w_cur);
  assign w_sum   = label_r ? (w_ext + $signed(SUM_W'(step))) : (w_ext - $signed(SUM_W'(step)));

  always_comb begin
    if (w_sum > W_MAX)      w_new = W_MAX[WEIGHT_W-1:0];
    else if (w_sum < W_MIN) w_new = W_MIN[WEIGHT_W-1:0];
    else                    w_new = w_sum[WEIGHT_W-1:0];
  end

  always_comb begin
    wr_data           = sel_data_r;
    wr_data[sel_lane] = w_new;
  end

  // report zero for a bad index, the stored weight for a classify request
  assign wout = !sel_ok ? '0 : (req_r ? w_new : w_cur);

  logic signed [WEIGHT_W-1:0] wout_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) wout_r <= wout;
  end

  // ---------------- result register ----------------
  lrt_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.probability     <= prob_r;
      out_data_r.predicted_class <= (prob_r >= P_HALF);
      out_data_r.updated_weight  <= wout_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && rd_en))
    else $error("weight write overlaps a scan read");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("new request taken while one is in progress");

  a_write_only_train: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (req_r && sel_ok))
    else $error("weight written without a valid train request");

  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIG_IDX) |-> (!p1_vld_r && !p2_vld_r && !rd_en))
    else $error("sigmoid index taken before the scan drained");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
